[hw/rtl/sha512_pkg.sv]
package sha512_pkg;

	localparam int unsigned BlockWords = 16;
	localparam int unsigned HashWords = 8;
	localparam int unsigned Rounds = 80;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned n);
		rotr64 = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 64'h6a09e667f3bcc908;
			3'd1: init_hash = 64'hbb67ae8584caa73b;
			3'd2: init_hash = 64'h3c6ef372fe94f82b;
			3'd3: init_hash = 64'ha54ff53a5f1d36f1;
			3'd4: init_hash = 64'h510e527fade682d1;
			3'd5: init_hash = 64'h9b05688c2b3e6c1f;
			3'd6: init_hash = 64'h1f83d9abfb41bd6b;
			default: init_hash = 64'h5be0cd19137e2179;
		endcase
	endfunction

	function automatic logic [63:0] round_k(input logic [6:0] i);
		logic [63:0] k [80];
		k = '{
			64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
			64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
			64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
			64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
			64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
			64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
			64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
			64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
			64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
			64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
			64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
			64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
			64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
			64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
			64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
			64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
			64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
			64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
			64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
			64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
		};
		round_k = k[i];
	endfunction

endpackage

[hw/rtl/sha512_ram.sv]
module sha512_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/sha512_round.sv]
module sha512_round
	import sha512_pkg::*;
(
	input  logic [63:0] v_in [8],
	input  logic [63:0] k,
	input  logic [63:0] w,
	output logic [63:0] v_out [8]
);

	logic [63:0] t1;
	logic [63:0] t2;

	// One compression round on the working variables.
	always_comb begin
		t1 = v_in[7] + (rotr64(v_in[4], 14) ^ rotr64(v_in[4], 18) ^ rotr64(v_in[4], 41))
		   + ((v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6])) + k + w;
		t2 = (rotr64(v_in[0], 28) ^ rotr64(v_in[0], 34) ^ rotr64(v_in[0], 39))
		   + ((v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]));
		v_out[7] = v_in[6];
		v_out[6] = v_in[5];
		v_out[5] = v_in[4];
		v_out[4] = v_in[3] + t1;
		v_out[3] = v_in[2];
		v_out[2] = v_in[1];
		v_out[1] = v_in[0];
		v_out[0] = t1 + t2;
	end

endmodule

[hw/rtl/sha512_hash_engine.sv]
// Channel  | Signals                                      | Direction
// input    | valid, stall, message_word, num_bytes, last  | in (stall out)
// output   | out_valid, out_stall, digest_word, ...       | out (out_stall in)
//
// A non-final item is accepted without stalling unless it fills the block; a full block then
// stalls input while the schedule is loaded, all 80 rounds run at one per cycle
// on the single round unit, and the result is added into the hash words.
// A last item writes one padding word per cycle to the end of the block, runs
// one or two compressions and emits eight digest words, one per unstalled cycle.
// arst_n clears control and loads the initial hash; input stall is high while busy.
module sha512_hash_engine
	import sha512_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [63:0] message_word,
	input  logic [3:0]  num_bytes,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	state_t      state_q, state_d;
	logic [63:0] hash_q [8];
	logic [63:0] v_q [8];
	logic [63:0] v_next [8];
	logic [63:0] w_q [16];
	logic [6:0]  fill_q;
	logic [127:0] len_q;
	logic [6:0]  round_q;
	logic [3:0]  lcnt_q;
	logic        fin_q;
	logic        pad2_q;
	logic        mark_q;
	logic [2:0]  oidx_q;
	logic [63:0] wt;
	logic [63:0] wnew;
	logic [3:0]  slot;
	logic [63:0] s0, s1;

	// Block buffer memory; the message schedule is kept in w_q during a run.
	logic        bwe;
	logic [3:0]  bwaddr, braddr;
	logic [63:0] bwdata, brdata;

	sha512_ram #(.Width(64), .Depth(BlockWords)) u_blk (
		.clk(clk), .we(bwe), .waddr(bwaddr), .wdata(bwdata),
		.raddr(braddr), .rdata(brdata)
	);

	sha512_round u_round (.v_in(v_q), .k(round_k(round_q)), .w(wt), .v_out(v_next));

	// Message schedule for the current round.
	always_comb begin
		slot = round_q[3:0];
		s1 = rotr64(w_q[slot + 4'd14], 19) ^ rotr64(w_q[slot + 4'd14], 61)
		   ^ (w_q[slot + 4'd14] >> 6);
		s0 = rotr64(w_q[slot + 4'd1], 1) ^ rotr64(w_q[slot + 4'd1], 8)
		   ^ (w_q[slot + 4'd1] >> 7);
		wnew = s1 + w_q[slot + 4'd9] + s0 + w_q[slot];
		wt = (round_q < 7'd16) ? w_q[slot] : wnew;
	end

	logic [3:0]  cnt;
	logic [63:0] mask;
	logic [63:0] padded;
	logic [7:0]  newfill;

	// Form the incoming word with the 0x80 marker for a short final item.
	always_comb begin
		cnt = (!last || num_bytes > 4'd8) ? 4'd8 : num_bytes;
		mask = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> (8 * cnt));
		padded = (message_word & mask) | ((cnt == 4'd8) ? 64'd0 : (64'h80 << (56 - 8 * cnt)));
		newfill = {1'b0, fill_q} + 8'd8;
	end

	always_comb begin
		state_d = state_q;
		stall = 1'b1;
		bwe = 1'b0;
		bwaddr = fill_q[6:3];
		bwdata = padded;
		braddr = lcnt_q;
		case (state_q)
			ST_IDLE: begin
				stall = 1'b0;
				if (valid) begin
					bwe = 1'b1;
					// A full block compresses first, even on the final item.
					if (newfill[7]) begin
						state_d = ST_LOAD;
					end else if (last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				// Marker of a full final item, zero fill, length at words 14 and 15 unless a second block follows.
				bwe = 1'b1;
				bwaddr = fill_q[6:3];
				if (mark_q) bwdata = {8'h80, 56'd0};
				else if (pad2_q) bwdata = 64'd0;
				else if (fill_q[6:3] == 4'd14) bwdata = len_q[127:64];
				else if (fill_q[6:3] == 4'd15) bwdata = len_q[63:0];
				else bwdata = 64'd0;
				if (fill_q[6:3] == 4'd15) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (lcnt_q == 4'd0 && round_q == 7'd1) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == 7'(Rounds - 1)) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (pad2_q) state_d = ST_PAD;
				else if (fin_q) state_d = ST_OUT;
				else state_d = ST_IDLE;
			end
			ST_OUT: begin
				if (!out_stall && oidx_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
			fill_q <= '0;
			len_q <= '0;
			round_q <= '0;
			lcnt_q <= '0;
			fin_q <= 1'b0;
			pad2_q <= 1'b0;
			mark_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					lcnt_q <= '0;
					round_q <= '0;
					if (valid) begin
						len_q <= len_q + {121'd0, cnt, 3'd0};
						fill_q <= newfill[6:0];
						fin_q <= last;
						// The length needs a second block when the marker lands
						// in word 14 or 15 or past the end of this block.
						pad2_q <= last && (fill_q[6:3] >= 4'd14
							|| (cnt == 4'd8 && fill_q[6:3] == 4'd13));
						// A full final item leaves the marker for the padding pass.
						mark_q <= last && (cnt == 4'd8);
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 7'd8;
					lcnt_q <= '0;
					round_q <= '0;
					mark_q <= 1'b0;
				end
				ST_LOAD: begin
					// Read the 16 words; data returns in the cycle after its address.
					lcnt_q <= lcnt_q + 4'd1;
					if (round_q == 7'd1) begin
						w_q[lcnt_q - 4'd1] <= brdata;
					end
					if (lcnt_q == 4'd0 && round_q == 7'd1) begin
						for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
						round_q <= '0;
					end else begin
						round_q <= 7'd1;
					end
				end
				ST_ROUND: begin
					if (round_q >= 7'd16) w_q[slot] <= wnew;
					v_q <= v_next;
					round_q <= round_q + 7'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					fill_q <= '0;
					if (pad2_q) begin
						pad2_q <= 1'b0;
					end
					oidx_q <= '0;
					round_q <= '0;
					lcnt_q <= '0;
				end
				ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
							len_q <= '0;
							fill_q <= '0;
							fin_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign digest_word = hash_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'd7);

	// Results appear only after a final item.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> fin_q)
		else $error("digest without final item");
	// A held digest word does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_index))
		else $error("digest changed under stall");
	// No input is taken while results are pending.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> stall)
		else $error("input taken during output");

endmodule

[verif/sha512_hash_engine_test.sv]
module sha512_hash_engine_test
	import sha512_pkg::*;
();

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        stall;
	logic [63:0] message_word;
	logic [3:0]  num_bytes;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha512_hash_engine dut (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .stall(stall),
		.message_word(message_word), .num_bytes(num_bytes), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  index;
		logic        final_flag;
	} digest_t;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  count;
		logic        final_flag;
		logic        has_golden;
		logic [63:0] golden_first;
	} stim_row_t;

	// Round constants and initial hash values, written out independently.
	localparam logic [63:0] K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};
	localparam logic [63:0] H0 [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	// Predictor state: chaining value, block buffer, fill level and 128-bit bit count.
	logic [63:0]  chain [8];
	logic [7:0]   buf_bytes [128];
	int unsigned  fill;
	logic [127:0] msg_bits;

	digest_t     digest_q [$];
	stim_row_t   stim_q [$];
	int unsigned errors;
	int unsigned digests_seen;
	int unsigned messages_done;
	bit          hold_sink;

	function automatic logic [63:0] ror(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic compress_block();
		logic [63:0] w [80];
		logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int t = 0; t < 16; t++)
			for (int j = 0; j < 8; j++)
				w[t][63-8*j -: 8] = buf_bytes[8*t + j];
		for (int t = 16; t < 80; t++)
			w[t] = (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
				+ (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int t = 0; t < 80; t++) begin
			t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) ^ (~e & g)) + K[t] + w[t];
			t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		buf_bytes[fill] = b;
		fill++;
		if (fill == 128) begin
			compress_block();
			fill = 0;
		end
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = H0[i];
		fill = 0;
		msg_bits = '0;
	endtask

	// Predict digests for one accepted transaction; golden_first is checked when given.
	task automatic predict_digest(input stim_row_t r);
		int unsigned n;
		logic [127:0] len;
		n = (!r.final_flag || r.count > 8) ? 8 : r.count;
		for (int i = 0; i < n; i++)
			absorb_byte(r.word[63-8*i -: 8]);
		msg_bits += 128'(n * 8);
		if (r.final_flag) begin
			len = msg_bits;
			absorb_byte(8'h80);
			if (fill > 112)
				while (fill != 0)
					absorb_byte(8'h00);
			while (fill < 112)
				absorb_byte(8'h00);
			for (int i = 0; i < 16; i++)
				absorb_byte(len[127-8*i -: 8]);
			if (r.has_golden && chain[0] !== r.golden_first) begin
				$error("golden digest_word: expected %h actual %h", r.golden_first, chain[0]);
				errors++;
			end
			for (int i = 0; i < HashWords; i++)
				digest_q.push_back('{chain[i], 3'(i), i == 7});
			restart_hash();
		end
	endtask

	always #2 clk = ~clk;

	// Output side: compare each digest transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest transaction: digest_word %h", digest_word);
				errors++;
			end else begin
				digest_t exp_d;
				exp_d = digest_q.pop_front();
				digests_seen++;
				if (digest_word !== exp_d.word) begin
					$error("digest_word: expected %h actual %h", exp_d.word, digest_word);
					errors++;
				end
				if (word_index !== exp_d.index) begin
					$error("word_index: expected %0d actual %0d", exp_d.index, word_index);
					errors++;
				end
				if (last_word !== exp_d.final_flag) begin
					$error("last_word: expected %0d actual %0d", exp_d.final_flag, last_word);
					errors++;
				end
			end
		end
	end

	// Random output stall: mostly short, occasionally long, with free-running stretches.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_stall <= 1'b0;
			end else begin
				n = $urandom_range(0, 99);
				if (n < 40) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end else if (n < 93) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 60)) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Queue one message of random length with random tail count.
	task automatic queue_message(input int unsigned words, input bit odd_count);
		stim_row_t r;
		for (int i = 0; i < words; i++) begin
			r.word = {$urandom, $urandom};
			r.final_flag = (i == words - 1);
			r.count = r.final_flag ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
			if (r.final_flag && odd_count)
				r.count = 4'($urandom_range(9, 15));
			r.has_golden = 1'b0;
			r.golden_first = '0;
			stim_q.push_back(r);
		end
	endtask

	// Drive one transaction and hold it until accepted.
	task automatic send_row(input stim_row_t r);
		valid <= 1'b1;
		message_word <= r.word;
		num_bytes <= r.count;
		last <= r.final_flag;
		do @(posedge clk); while (stall);
		predict_digest(r);
		if (r.final_flag)
			messages_done++;
	endtask

	task automatic sender_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 55)
			return;
		valid <= 1'b0;
		if (n < 95)
			repeat ($urandom_range(1, 3)) @(posedge clk);
		else
			repeat ($urandom_range(8, 40)) @(posedge clk);
	endtask

	initial begin
		stim_row_t r;
		int unsigned wait_cycles;
		clk = 1'b0;
		arst_n = 1'b0;
		valid = 1'b0;
		message_word = '0;
		num_bytes = '0;
		last = 1'b0;
		hold_sink = 1'b0;
		errors = 0;
		digests_seen = 0;
		messages_done = 0;
		restart_hash();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: empty message and "abc" have known digests.
		stim_q.push_back('{64'h0, 4'd0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd});
		stim_q.push_back('{64'h6162630000000000, 4'd3, 1'b1, 1'b1, 64'hddaf35a193617aba});
		stim_q.push_back('{64'hffffffffffffffff, 4'd8, 1'b1, 1'b0, '0});
		stim_q.push_back('{64'hffffffffffffffff, 4'd15, 1'b0, 1'b0, '0});
		stim_q.push_back('{64'h0123456789abcdef, 4'd15, 1'b1, 1'b0, '0});
		stim_q.push_back('{64'h8000000000000001, 4'd1, 1'b1, 1'b0, '0});
		// 15 words then 0 bytes: the marker lands in the length field, so padding spans two blocks.
		for (int i = 0; i < 14; i++)
			stim_q.push_back('{{$urandom, $urandom}, 4'd0, 1'b0, 1'b0, '0});
		stim_q.push_back('{64'h0, 4'd7, 1'b0, 1'b0, '0});
		stim_q.push_back('{64'h00ff00ff00ff00ff, 4'd0, 1'b1, 1'b0, '0});
		while (stim_q.size() != 0) begin
			r = stim_q.pop_front();
			send_row(r);
			sender_gap();
		end
		valid <= 1'b0;

		// Drain: sender pauses until every digest has been taken.
		hold_sink = 1'b1;
		while (digest_q.size() != 0)
			@(posedge clk);
		hold_sink = 1'b0;

		// Random messages, mostly short, a few spanning several blocks.
		while (stim_q.size() < 120) begin
			if ($urandom_range(0, 9) == 0)
				queue_message($urandom_range(15, 40), $urandom_range(0, 3) == 0);
			else
				queue_message($urandom_range(1, 17), $urandom_range(0, 3) == 0);
		end
		while (stim_q.size() != 0) begin
			r = stim_q.pop_front();
			send_row(r);
			sender_gap();
		end
		valid <= 1'b0;

		wait_cycles = 0;
		while (digest_q.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (digest_q.size() != 0) begin
			$error("%0d digest words never arrived", digest_q.size());
			errors++;
		end
		$display("Hashed %0d messages and checked %0d digest words,", messages_done, digests_seen);
		$display("including empty, single-byte, two-block padding and overlong tail counts.");
		if (errors == 0)
			$display("PASS sha512_hash_engine");
		else
			$display("FAIL sha512_hash_engine");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL sha512_hash_engine");
		$finish;
	end

endmodule
